// ===== rtl/core/pfdc_pkg.sv =====
// Shared constants and codes for the PWM frequency and duty capture block.
package pfdc_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int STAMP_W          = 16;
    localparam int TICKS_W          = 16;
    localparam int CLOCK_W          = 27;
    localparam int FREQ_W           = 27;
    localparam int DUTY_W           = 17;
    localparam int DUTY_SHIFT       = 16;

    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RST = CLOCK_W'(80000000);

    localparam logic [1:0] PH_RISE = 2'd0;
    localparam logic [1:0] PH_FALL = 2'd1;
    localparam logic [1:0] PH_NEXT = 2'd2;

endpackage

// ===== rtl/core/pfdc_cap_if.sv =====
// Capture-stamp channel and measurement-result channel interfaces.
interface pfdc_cap_if
    import pfdc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] capture_stamp;

    modport source (output valid, output capture_stamp, input ready);
    modport sink   (input valid, input capture_stamp, output ready);
endinterface

interface pfdc_meas_if
    import pfdc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               arm_falling_edge;
    logic               measurement_done;
    logic [TICKS_W-1:0] high_ticks;
    logic [TICKS_W-1:0] low_ticks;
    logic [FREQ_W-1:0]  frequency_hz;
    logic [DUTY_W-1:0]  duty_fraction;

    modport source (output valid, output arm_falling_edge, output measurement_done,
                    output high_ticks, output low_ticks, output frequency_hz,
                    output duty_fraction, input ready);
    modport sink   (input valid, input arm_falling_edge, input measurement_done,
                    input high_ticks, input low_ticks, input frequency_hz,
                    input duty_fraction, output ready);
endinterface

// ===== rtl/core/pfdc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module pfdc_div
    import pfdc_pkg::*;
#(
    parameter int DW = 32,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;
    localparam logic [CW-1:0] LAST = CW'(DW - 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;

    logic [VW:0] rem_sh;
    logic [VW:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign diff   = rem_sh - {1'b0, i_divisor};
    assign ge     = rem_sh >= {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
            n_quo = {r_quo[DW-2:0], ge};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/pwm_frequency_duty_capture.sv =====
// PWM frequency and duty capture: top level with edge sequencer and shared divider.
//
// Feed one timer capture stamp per input edge: rising, falling, then the next rising.
// The first two words go straight to the output with the edge to arm next.
// The third word yields high/low ticks, frequency = clock_hz / period and duty as
// floor(high * 65536 / period) in Q1.16; both quotients come from one restoring
// divider run back to back, one bit per cycle. Input ready is low while a word is
// in work; one finished result may wait in the output register.
module pwm_frequency_duty_capture
    import pfdc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CLOCK_W-1:0] i_cfg_wr_data,
    pfdc_cap_if.sink           i_cap,
    pfdc_meas_if.source        o_meas
);

    localparam int CB = COUNTER_BITS;
    localparam int SW = (CB < STAMP_W) ? CB : STAMP_W;
    localparam int PW = CB + 1;
    localparam int XW = (CB > TICKS_W) ? CB : TICKS_W;
    localparam int DW = (CLOCK_W > CB + DUTY_SHIFT) ? CLOCK_W : CB + DUTY_SHIFT;
    localparam logic [CB-1:0] MAXV = {CB{1'b1}};

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FREQ_GO = 3'd1;
    localparam logic [2:0] ST_FREQ    = 3'd2;
    localparam logic [2:0] ST_DUTY_GO = 3'd3;
    localparam logic [2:0] ST_DUTY    = 3'd4;
    localparam logic [2:0] ST_PUSH    = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_phase, n_phase;
    logic [CLOCK_W-1:0] r_clock_hz;
    logic [SW-1:0]      r_rise, r_fall;
    logic [CB-1:0]      r_hi, r_lo;
    logic [PW-1:0]      r_period;
    logic               r_arm, r_done;
    logic [FREQ_W-1:0]  r_freq;
    logic [DUTY_W-1:0]  r_duty;

    logic               r_out_valid;
    logic               r_o_arm, r_o_done;
    logic [TICKS_W-1:0] r_o_hi, r_o_lo;
    logic [FREQ_W-1:0]  r_o_freq;
    logic [DUTY_W-1:0]  r_o_duty;

    logic [SW-1:0] stamp;
    logic [CB-1:0] rise_x, fall_x, stamp_x, span_hi, span_lo;
    logic          accept, push, out_free;
    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_quo;
    logic [XW-1:0] hi_x, lo_x;

    assign stamp   = i_cap.capture_stamp[SW-1:0];
    assign rise_x  = CB'(r_rise);
    assign fall_x  = CB'(r_fall);
    assign stamp_x = CB'(stamp);
    assign span_hi = (fall_x > rise_x) ? fall_x - rise_x : MAXV - rise_x + fall_x;
    assign span_lo = (stamp_x > fall_x) ? stamp_x - fall_x : MAXV - fall_x + stamp_x;

    assign i_cap.ready = (r_state == ST_IDLE);
    assign accept      = i_cap.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_meas.ready;
    assign push        = (r_state == ST_PUSH) && out_free;

    assign div_start    = (r_state == ST_FREQ_GO) || (r_state == ST_DUTY_GO);
    assign div_dividend = (r_state == ST_FREQ_GO) ? DW'(r_clock_hz)
                                                  : DW'({r_hi, {DUTY_SHIFT{1'b0}}});

    pfdc_div #(
        .DW (DW),
        .VW (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_period),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (r_phase)
                        PH_FALL: begin
                            n_phase = PH_NEXT;
                            n_state = ST_PUSH;
                        end
                        PH_NEXT: begin
                            n_phase = PH_RISE;
                            n_state = ST_FREQ_GO;
                        end
                        default: begin
                            n_phase = PH_FALL;
                            n_state = ST_PUSH;
                        end
                    endcase
                end
            end
            ST_FREQ_GO: n_state = ST_FREQ;
            ST_FREQ:    if (div_done) n_state = ST_DUTY_GO;
            ST_DUTY_GO: n_state = ST_DUTY;
            ST_DUTY:    if (div_done) n_state = ST_PUSH;
            ST_PUSH:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_RISE;
            r_clock_hz <= CLOCK_HZ_RST;
            r_rise     <= '0;
            r_fall     <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (i_cfg_wr_en) begin
                r_clock_hz <= i_cfg_wr_data;
            end
            if (accept && (r_phase == PH_FALL)) begin
                r_fall <= stamp;
            end else if (accept && (r_phase != PH_NEXT)) begin
                r_rise <= stamp;
            end
        end
    end

    // pending result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_arm <= (r_phase != PH_FALL) && (r_phase != PH_NEXT);
            if (r_phase == PH_NEXT) begin
                r_done   <= 1'b1;
                r_hi     <= span_hi;
                r_lo     <= span_lo;
                r_period <= PW'(span_hi) + PW'(span_lo);
            end else begin
                r_done <= 1'b0;
                r_hi   <= '0;
                r_lo   <= '0;
                r_freq <= '0;
                r_duty <= '0;
            end
        end
        if ((r_state == ST_FREQ) && div_done) begin
            r_freq <= (r_period == '0) ? '0 : div_quo[FREQ_W-1:0];
        end
        if ((r_state == ST_DUTY) && div_done) begin
            r_duty <= (r_period == '0) ? '0 : div_quo[DUTY_W-1:0];
        end
    end

    assign hi_x = XW'(r_hi);
    assign lo_x = XW'(r_lo);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_meas.ready) begin
            r_out_valid <= 1'b0;
        end
        if (push) begin
            r_o_arm  <= r_arm;
            r_o_done <= r_done;
            r_o_hi   <= hi_x[TICKS_W-1:0];
            r_o_lo   <= lo_x[TICKS_W-1:0];
            r_o_freq <= r_freq;
            r_o_duty <= r_duty;
        end
    end

    assign o_meas.valid            = r_out_valid;
    assign o_meas.arm_falling_edge = r_o_arm;
    assign o_meas.measurement_done = r_o_done;
    assign o_meas.high_ticks       = r_o_hi;
    assign o_meas.low_ticks        = r_o_lo;
    assign o_meas.frequency_hz     = r_o_freq;
    assign o_meas.duty_fraction    = r_o_duty;

endmodule

// ===== test/tb_pwm_frequency_duty_capture.sv =====
// Self-checking testbench for the PWM frequency and duty capture block.
module tb_pwm_frequency_duty_capture;
    import pfdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 16;
    localparam int DRAIN_WAIT  = 100;
    localparam int STALL_LIMIT = 4000;
    localparam int N_DIRECTED  = 21;
    localparam int N_PHASES    = 6;
    localparam int PHASE_WORDS = 66;

    typedef struct packed {
        logic               arm_falling_edge;
        logic               measurement_done;
        logic [TICKS_W-1:0] high_ticks;
        logic [TICKS_W-1:0] low_ticks;
        logic [FREQ_W-1:0]  frequency_hz;
        logic [DUTY_W-1:0]  duty_fraction;
    } meas_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               typed;
        meas_t              want;
    } stim_row_t;

    // rise, fall, next rise; typed rows are read straight off the wrap rule
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{16'h0000, 1'b1, '{1'b1, 1'b0, 16'd0, 16'd0, 27'd0, 17'd0}},
        '{16'h0000, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 27'd0, 17'd0}},
        '{16'h0000, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 27'd610, 17'd32768}},
        '{16'h0000, 1'b0, '0},
        '{16'h0001, 1'b0, '0},
        '{16'h0002, 1'b1, '{1'b0, 1'b1, 16'd1, 16'd1, 27'd40000000, 17'd32768}},
        '{16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'd0, 16'd0, 27'd0, 17'd0}},
        '{16'h0000, 1'b0, '0},
        '{16'h0001, 1'b1, '{1'b0, 1'b1, 16'd0, 16'd1, 27'd80000000, 17'd0}},
        '{16'h0001, 1'b0, '0},
        '{16'hFFFF, 1'b0, '0},
        '{16'h0000, 1'b1, '{1'b0, 1'b1, 16'd65534, 16'd0, 27'd1220, 17'd65536}},
        '{16'h0005, 1'b0, '0},
        '{16'h0004, 1'b0, '0},
        '{16'h0005, 1'b1, '{1'b0, 1'b1, 16'd65534, 16'd1, 27'd1220, 17'd65534}},
        '{16'hAAAA, 1'b0, '0},
        '{16'h5555, 1'b0, '0},
        '{16'hFFFF, 1'b0, '0},
        '{16'h5555, 1'b0, '0},
        '{16'hAAAA, 1'b0, '0},
        '{16'h0000, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [CLOCK_W-1:0] i_cfg_wr_data;

    pfdc_cap_if  cap ();
    pfdc_meas_if meas ();

    pwm_frequency_duty_capture u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cap         (cap),
        .o_meas        (meas)
    );

    // shadow of the block's state
    logic [CLOCK_W-1:0] clock_hz_q;
    logic [1:0]         phase_q;
    logic [STAMP_W-1:0] rise_q;
    logic [STAMP_W-1:0] fall_q;

    meas_t              meas_expected [$];
    logic               word_typed;
    meas_t              word_want;
    logic               steady;
    logic [STAMP_W-1:0] last_stamp;
    int                 err_count;
    int                 words_sent;
    int                 meas_checked;
    int                 periods_seen;
    int                 stall_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [TICKS_W-1:0] wrap_span(input logic [STAMP_W-1:0] a,
                                                     input logic [STAMP_W-1:0] b);
        if (b > a)
            return b - a;
        return 16'hFFFF - a + b;
    endfunction

    function automatic meas_t measure_edge(input logic [STAMP_W-1:0] stamp);
        meas_t           m;
        logic [16:0]     period;
        logic [31:0]     duty_full;
        m = '0;
        case (phase_q)
            PH_FALL: begin
                fall_q  = stamp;
                phase_q = PH_NEXT;
            end
            PH_NEXT: begin
                m.high_ticks       = wrap_span(rise_q, fall_q);
                m.low_ticks        = wrap_span(fall_q, stamp);
                m.measurement_done = 1'b1;
                period = {1'b0, m.high_ticks} + {1'b0, m.low_ticks};
                if (period != 0) begin
                    m.frequency_hz  = FREQ_W'(clock_hz_q / period);
                    duty_full       = {m.high_ticks, 16'd0} / period;
                    m.duty_fraction = duty_full[DUTY_W-1:0];
                end
                phase_q = PH_RISE;
            end
            default: begin
                rise_q             = stamp;
                m.arm_falling_edge = 1'b1;
                phase_q            = PH_FALL;
            end
        endcase
        return m;
    endfunction

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        err_count++;
    endtask

    task automatic compare_meas(input meas_t want);
        if (meas.arm_falling_edge !== want.arm_falling_edge)
            report("arm_falling_edge", meas.arm_falling_edge, want.arm_falling_edge);
        if (meas.measurement_done !== want.measurement_done)
            report("measurement_done", meas.measurement_done, want.measurement_done);
        if (meas.high_ticks !== want.high_ticks)
            report("high_ticks", meas.high_ticks, want.high_ticks);
        if (meas.low_ticks !== want.low_ticks)
            report("low_ticks", meas.low_ticks, want.low_ticks);
        if (meas.frequency_hz !== want.frequency_hz)
            report("frequency_hz", meas.frequency_hz, want.frequency_hz);
        if (meas.duty_fraction !== want.duty_fraction)
            report("duty_fraction", meas.duty_fraction, want.duty_fraction);
    endtask

    // accepted words feed the predictor; returned words are checked in order
    always @(posedge i_clk) begin
        meas_t m;
        if (i_rst_n) begin
            if (meas.valid && meas.ready) begin
                meas_checked++;
                if (meas_expected.size() == 0) begin
                    $display("[%0t] result word with nothing expected", $realtime);
                    err_count++;
                end else begin
                    m = meas_expected.pop_front();
                    if (m.measurement_done)
                        periods_seen++;
                    compare_meas(m);
                end
            end
            if (cap.valid && cap.ready) begin
                m = measure_edge(cap.capture_stamp);
                if (word_typed)
                    m = word_want;
                meas_expected.push_back(m);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cap.valid && cap.ready) || (meas.valid && meas.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("pwm_frequency_duty_capture verification failed");
            $finish;
        end
    end

    always @(negedge i_clk)
        meas.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    task automatic send_word(input logic [STAMP_W-1:0] stamp, input logic typed,
                             input meas_t want);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            cap.valid <= 1'b0;
            do
                @(negedge i_clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        cap.valid         <= 1'b1;
        cap.capture_stamp <= stamp;
        word_typed        <= typed;
        word_want         <= want;
        do
            @(posedge i_clk);
        while (!cap.ready);
        words_sent++;
        last_stamp = stamp;
        @(negedge i_clk);
    endtask

    task automatic drain();
        cap.valid <= 1'b0;
        while (meas_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_clock_hz(input logic [CLOCK_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        clock_hz_q = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [STAMP_W-1:0] pick_stamp(input logic [STAMP_W-1:0] prev);
        case ($urandom_range(9))
            4, 5:    return prev + STAMP_W'($urandom_range(1, 64));
            6:       return prev - STAMP_W'($urandom_range(0, 64));
            7:       return 16'h0000;
            8:       return 16'hFFFF;
            9:       return prev;
            default: return STAMP_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [CLOCK_W-1:0] clock_plan [N_PHASES];
        clock_plan = '{27'd1, 27'd120000000, 27'd0, 27'h7FFFFFF,
                       CLOCK_W'($urandom_range(1, 120000000)), 27'd80000000};
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        cap.valid         = 1'b0;
        cap.capture_stamp = '0;
        meas.ready        = 1'b0;
        word_typed        = 1'b0;
        word_want         = '0;
        steady            = 1'b0;
        last_stamp        = '0;
        err_count         = 0;
        words_sent        = 0;
        meas_checked      = 0;
        periods_seen      = 0;
        stall_cycles      = 0;
        clock_hz_q        = CLOCK_HZ_RST;
        phase_q           = PH_RISE;
        rise_q            = '0;
        fall_q            = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_word(directed_rows[r].stamp, directed_rows[r].typed, directed_rows[r].want);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_clock_hz(clock_plan[p]);
            steady = (p == 3);
            for (int w = 0; w < PHASE_WORDS; w++) begin
                // hold off mid-phase until every result is back
                if (p == 1 && w == PHASE_WORDS / 2)
                    drain();
                send_word(pick_stamp(last_stamp), 1'b0, '0);
            end
            drain();
        end

        $display("sent %0d capture words over %0d clock settings (incl. 0 and full scale)",
                 words_sent, N_PHASES + 1);
        $display("checked %0d result words, %0d completed periods", meas_checked,
                 periods_seen);
        if (err_count == 0)
            $display("pwm_frequency_duty_capture verification clean");
        else
            $display("pwm_frequency_duty_capture verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pfdc_pkg.sv
rtl/core/pfdc_cap_if.sv
rtl/core/pfdc_div.sv
rtl/core/pwm_frequency_duty_capture.sv
test/tb_pwm_frequency_duty_capture.sv
